// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, trig, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed: next-cycle check");

`else

`define ASSERT_ALWAYS(name, clk, rst_n, cond)
`define ASSERT_NEXT(name, clk, rst_n, trig, cond)

`endif

`endif

// ===== src/dsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// dsrm_pkg
// Shared constants and types of the dot-star matcher.
// ----------------------------------------------------------------------------
package dsrm_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int POS_W        = MAX_ELEMENTS + 1;
  localparam int LEN_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int LVL_N        = $clog2(POS_W);

  localparam logic [7:0] ANY_CHAR = 8'd46;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_RESTART = 2'd2,
    OP_BYTE    = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic       star;
  } cmd_t;

  typedef struct packed {
    logic status;
    logic matched;
    logic alive;
  } res_t;

endpackage

// ===== src/dsrm_front.sv =====
// ----------------------------------------------------------------------------
// dsrm_front
// Accepts input beats, decodes the item kind and queues commands (2 deep).
// ----------------------------------------------------------------------------
module dsrm_front import dsrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] char_value_i,
  input  logic       starred_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_ready_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push_ok, pop_ok;
  cmd_t       cmd_in;

  // Decode the item kind into an operation.
  always_comb begin
    cmd_in.ch   = char_value_i;
    cmd_in.star = starred_i;
    unique case (kind_i)
      2'd0:    cmd_in.op = OP_CLEAR;
      2'd1:    cmd_in.op = OP_APPEND;
      2'd2:    cmd_in.op = OP_RESTART;
      default: cmd_in.op = OP_BYTE;
    endcase
  end

  assign full_o      = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push_ok     = push_i & ~full_o;
  assign pop_ok      = cmd_valid_o & cmd_ready_i;

  always_comb begin
    wr_ptr_d = push_ok ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_ok  ? ~rd_ptr_q : rd_ptr_q;
    unique case ({push_ok, pop_ok})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== src/dsrm_back.sv =====
// ----------------------------------------------------------------------------
// dsrm_back
// Holds the pattern, advances the position automaton, queues results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsrm_back import dsrm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_ready_o,
  output logic res_empty_o,
  output res_t res_o,
  input  logic res_pop_i
);

  logic [7:0]       chars_q [MAX_ELEMENTS];
  logic             stars_q [MAX_ELEMENTS];
  logic [LEN_W-1:0] len_q, len_d;
  logic [POS_W-1:0] act_q, act_d;

  res_t             res_slot_q [2];
  logic             res_wr_q, res_rd_q;
  logic [1:0]       res_cnt_q, res_cnt_d;

  logic             go, wr_en, res_pop, status;
  logic [POS_W-1:0] raw, closed, prop, self_v, adv_v;
  res_t             res_in;

  // Closure over starred elements as a prefix network: position k+1 inherits
  // position k through a starred element k; log-depth doubling.
  function automatic logic [POS_W-1:0] close_set(input logic [POS_W-1:0] set_in,
                                                  input logic [POS_W-1:0] pass_in);
    logic [POS_W-1:0] g, p, g_n, p_n;
    g = set_in;
    p = pass_in;
    for (int l = 0; l < LVL_N; l++) begin
      g_n = g;
      p_n = p;
      for (int k = 0; k < POS_W; k++) begin
        if (k >= (1 << l)) begin
          g_n[k] = g[k] | (p[k] & g[k - (1 << l)]);
          p_n[k] = p[k] & p[k - (1 << l)];
        end
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

  assign cmd_ready_o = (res_cnt_q != 2'd2);
  assign go          = cmd_valid_i & cmd_ready_o;

  // Byte step over the closed set held in act_q.
  always_comb begin
    self_v = '0;
    adv_v  = '0;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (act_q[k] && (LEN_W'(k) < len_q) &&
          ((chars_q[k] == ANY_CHAR) || (chars_q[k] == cmd_i.ch))) begin
        if (stars_q[k]) begin
          self_v[k] = 1'b1;
        end else begin
          adv_v[k + 1] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    len_d  = len_q;
    raw    = POS_W'(1);
    status = 1'b0;
    wr_en  = 1'b0;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        len_d = '0;
      end
      OP_APPEND: begin
        if (len_q < LEN_W'(MAX_ELEMENTS)) begin
          wr_en = go;
          len_d = len_q + LEN_W'(1);
        end else begin
          status = 1'b1;
        end
      end
      OP_RESTART: begin
        raw = POS_W'(1);
      end
      OP_BYTE: begin
        raw = self_v | adv_v;
      end
      default: begin
        raw = POS_W'(1);
      end
    endcase
  end

  // Pass vector of the pattern as it stands after this command.
  always_comb begin
    prop = '0;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (LEN_W'(k) < len_d) begin
        if (wr_en && (LEN_W'(k) == len_q)) begin
          prop[k + 1] = cmd_i.star;
        end else begin
          prop[k + 1] = stars_q[k];
        end
      end
    end
  end

  assign closed         = close_set(raw, prop);
  assign act_d          = closed;
  assign res_in.status  = status;
  assign res_in.matched = closed[len_d];
  assign res_in.alive   = |closed;

  assign res_empty_o = (res_cnt_q == 2'd0);
  assign res_o       = res_slot_q[res_rd_q];
  assign res_pop     = res_pop_i & ~res_empty_o;

  always_comb begin
    unique case ({go, res_pop})
      2'b10:   res_cnt_d = res_cnt_q + 2'd1;
      2'b01:   res_cnt_d = res_cnt_q - 2'd1;
      default: res_cnt_d = res_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      act_q     <= POS_W'(1);
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (go) begin
        len_q    <= len_d;
        act_q    <= act_d;
        res_wr_q <= ~res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= ~res_rd_q;
      end
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      res_slot_q[res_wr_q] <= res_in;
    end
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (wr_en && (LEN_W'(k) == len_q)) begin
        chars_q[k] <= cmd_i.ch;
        stars_q[k] <= cmd_i.star;
      end
    end
  end

  `ASSERT_ALWAYS(a_res_cnt_bound, clk_i, rst_ni, res_cnt_q <= 2'd2)
  `ASSERT_ALWAYS(a_len_bound, clk_i, rst_ni, len_q <= LEN_W'(MAX_ELEMENTS))
  `ASSERT_NEXT(a_restart_seeds, clk_i, rst_ni, go && (cmd_i.op != OP_BYTE), act_q[0])

endmodule

// ===== src/dot_star_regex_matcher.sv =====
// ----------------------------------------------------------------------------
// dot_star_regex_matcher
// Whole-string matcher for patterns of literal or '.' elements, each
// optionally starred, over a stream of text bytes.
// ----------------------------------------------------------------------------
// An item is registered in the command queue, then its result in the result queue.
// Throughput: one item per cycle unless the result queue is full; the
//   automaton update (byte compare plus a log-depth star closure) is combinational.
// Reset (rst_ni low, asynchronous): queues empty, pattern length 0, only
//   position zero active. Pattern storage is not cleared.
// ----------------------------------------------------------------------------
module dot_star_regex_matcher import dsrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input queue side
  input  logic       push,
  output logic       full,
  input  logic [1:0] kind_i,
  input  logic [7:0] char_value_i,
  input  logic       starred_i,
  // result queue side
  output logic       empty,
  input  logic       pop,
  output logic       status_o,
  output logic       matched_o,
  output logic       alive_o
);

  // Command beat between the front end and the back end.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  res_t res;

  // Front end: take the beat, decode its kind, hold it in a two-deep queue so
  // the input side can run ahead of a stalled back end until both slots fill.
  dsrm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .kind_i       (kind_i),
    .char_value_i (char_value_i),
    .starred_i    (starred_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_ready_i  (cmd_ready)
  );

  // Back end: run the command against the pattern store and the active
  // position vector, then drop the result into a two-deep result queue that
  // the consumer drains with pop.
  dsrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_empty_o (empty),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  // Split the result beat onto its ports.
  assign status_o  = res.status;
  assign matched_o = res.matched;
  assign alive_o   = res.alive;

endmodule
